// ----- design/ffpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffpd_pkg: shared types and constants of the fixed frame packet decoder
// Holds the request structs, controller commands, status codes, header
// offsets and the bytewise CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package ffpd_pkg;

  // Frame layout that does not depend on the body size.
  localparam int HEAD_BYTES = 12;
  localparam int TAIL_BYTES = 2;
  localparam int HDR_MAGIC0 = 0;
  localparam int HDR_MAGIC1 = 1;
  localparam int HDR_VERSION = 2;
  localparam int HDR_KIND = 3;
  localparam int HDR_SENDER = 4;
  localparam int HDR_TARGET = 5;
  localparam int HDR_SEQ_HI = 6;
  localparam int HDR_SEQ_LO = 7;
  localparam int HDR_ACK_HI = 8;
  localparam int HDR_ACK_LO = 9;
  localparam int HDR_LENGTH = 10;
  localparam int HDR_FLAGS = 11;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Result status codes.
  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_LENGTH = 3'd1;
  localparam logic [2:0] STATUS_MAGIC = 3'd2;
  localparam logic [2:0] STATUS_VERSION = 3'd3;
  localparam logic [2:0] STATUS_KIND = 3'd4;
  localparam logic [2:0] STATUS_TARGET = 3'd5;
  localparam logic [2:0] STATUS_BODY_LENGTH = 3'd6;
  localparam logic [2:0] STATUS_CRC = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH_MIN = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic [7:0]  msg_kind;
    logic [7:0]  sender_node;
    logic [7:0]  target_node;
    logic [15:0] seq_number;
    logic [15:0] ack_number;
    logic [4:0]  body_length;
    logic [7:0]  flag_bits;
    logic [7:0]  body_byte;
    logic [3:0]  body_index;
    logic        run_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_CHECK,
    ST_DECIDE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic latch_status;
    logic load_error;
    logic load_body;
    logic step_index;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_ok;
    logic last_index;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/fixed_frame_packet_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_frame_packet_decoder_core: fixed-length frame deframer with CRC check
// Takes one received byte per request, checks a finished frame and emits
// either one error result or one result per body byte.
// ----------------------------------------------------------------------------
// A frame is 14 + BODY_BYTES bytes (30 by default): two magic bytes, version, message kind,
// sender, target, big-endian sequence and acknowledge, body length, flags,
// the body and a big-endian CRC-16/CCITT-FALSE over all preceding bytes.
// While a frame is being collected the block takes one byte request per
// clock. The request that carries frame_end starts a check, which latches
// the status and then decides; the block then emits either a single error
// result, or BODY_BYTES results bounded by the registered read of the body
// memory, which is fetched once per result ahead of loading the result
// register. No byte request is taken from the end of a frame until its last
// result has been loaded into the output register. The check reports the
// first failure in the order length, magic, version, kind range, target,
// body length range, CRC. Bytes past the frame length are ignored and force
// a length error.
// Configuration writes are accepted in any cycle but must only be issued
// while the block is idle; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module fixed_frame_packet_decoder_core #(
  parameter int BODY_BYTES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           byte_valid,
  output logic                                byte_ready,
  input  wire ffpd_pkg::in_item_t             byte_item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output ffpd_pkg::out_item_t                 result_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ffpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  ffpd_pkg::cmd_t cmd;
  ffpd_pkg::sts_t sts;

  // Configuration registers are plain flops, so a write never stalls.
  assign cfg_ready = 1'b1;

  // The controller sequences collection, checking and emission.
  ffpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .frame_end  (byte_item.frame_end),
    .byte_ready (byte_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds all frame storage, the check and the result register.
  ffpd_datapath #(
    .BODY_BYTES (BODY_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .byte_item    (byte_item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

// ----- design/ffpd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffpd_ctrl: frame decoder controller
// Sequences byte collection, the end-of-frame check and result emission.
// ----------------------------------------------------------------------------
module ffpd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  input  wire logic           frame_end,
  output logic                byte_ready,
  input  wire ffpd_pkg::sts_t sts,
  output ffpd_pkg::cmd_t      cmd
);

  ffpd_pkg::state_t state;
  ffpd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpd_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    byte_ready = 1'b0;
    case (state)
      ffpd_pkg::ST_COLLECT: begin
        byte_ready = 1'b1;
        if (byte_valid) begin
          cmd.take_byte = 1'b1;
          if (frame_end) begin
            state_next = ffpd_pkg::ST_CHECK;
          end
        end
      end
      ffpd_pkg::ST_CHECK: begin
        cmd.latch_status = 1'b1;
        state_next = ffpd_pkg::ST_DECIDE;
      end
      ffpd_pkg::ST_DECIDE: begin
        if (sts.frame_ok) begin
          state_next = ffpd_pkg::ST_EMIT;
        end else if (sts.out_free) begin
          cmd.load_error = 1'b1;
          state_next = ffpd_pkg::ST_COLLECT;
        end
      end
      ffpd_pkg::ST_FETCH: begin
        state_next = ffpd_pkg::ST_EMIT;
      end
      ffpd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_body = 1'b1;
          if (sts.last_index) begin
            state_next = ffpd_pkg::ST_COLLECT;
          end else begin
            cmd.step_index = 1'b1;
            state_next = ffpd_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ffpd_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/ffpd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffpd_datapath: frame decoder datapath
// Byte counter, CRC register, header and trailer registers, body memory,
// configuration registers, the frame check and the result register.
// ----------------------------------------------------------------------------
module ffpd_datapath #(
  parameter int BODY_BYTES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ffpd_pkg::cmd_t                     cmd,
  output ffpd_pkg::sts_t                          sts,
  input  wire ffpd_pkg::in_item_t                 byte_item,
  input  wire logic                               cfg_valid,
  input  wire logic [ffpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output ffpd_pkg::out_item_t                     result_item
);

  localparam int FRAME_BYTES = ffpd_pkg::HEAD_BYTES + BODY_BYTES + ffpd_pkg::TAIL_BYTES;
  localparam int CRC_AT = ffpd_pkg::HEAD_BYTES + BODY_BYTES;
  localparam int COUNT_CAP = FRAME_BYTES + 1;
  localparam int CNT_W = $clog2(COUNT_CAP + 1);
  localparam int IDX_W = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;

  // Configuration registers.
  logic [7:0] node_address;
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic [7:0] format_version;
  logic [7:0] kind_min;
  logic [7:0] kind_max;
  logic [4:0] body_length_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 8'd0;
      magic_first <= 8'd0;
      magic_second <= 8'd0;
      format_version <= 8'd0;
      kind_min <= 8'd0;
      kind_max <= 8'hFF;
      body_length_min <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffpd_pkg::CFG_NODE_ADDRESS: node_address <= cfg_data;
        ffpd_pkg::CFG_MAGIC_FIRST: magic_first <= cfg_data;
        ffpd_pkg::CFG_MAGIC_SECOND: magic_second <= cfg_data;
        ffpd_pkg::CFG_FORMAT_VERSION: format_version <= cfg_data;
        ffpd_pkg::CFG_KIND_MIN: kind_min <= cfg_data;
        ffpd_pkg::CFG_KIND_MAX: kind_max <= cfg_data;
        ffpd_pkg::CFG_BODY_LENGTH_MIN: body_length_min <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Byte position and running CRC.
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      crc_register;
  logic [7:0]       rx;
  logic             in_head;
  logic             in_body;
  logic             before_crc;
  logic [CNT_W-1:0] body_off;
  logic [IDX_W-1:0] wr_addr;

  assign rx = byte_item.rx_byte;
  assign in_head = byte_count < CNT_W'(ffpd_pkg::HEAD_BYTES);
  assign before_crc = byte_count < CNT_W'(CRC_AT);
  assign in_body = !in_head && before_crc;
  assign body_off = byte_count - CNT_W'(ffpd_pkg::HEAD_BYTES);
  assign wr_addr = body_off[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_register <= ffpd_pkg::CRC_INIT;
    end else if (cmd.latch_status) begin
      byte_count <= '0;
      crc_register <= ffpd_pkg::CRC_INIT;
    end else if (cmd.take_byte) begin
      if (before_crc) begin
        crc_register <= ffpd_pkg::crc_feed(crc_register, rx);
      end
      if (byte_count < CNT_W'(COUNT_CAP)) begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  // Header and received CRC registers.
  logic [7:0]  hdr [ffpd_pkg::HEAD_BYTES];
  logic [15:0] crc_received;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      for (int i = 0; i < ffpd_pkg::HEAD_BYTES; i++) begin
        if (byte_count == CNT_W'(i)) begin
          hdr[i] <= rx;
        end
      end
      if (byte_count == CNT_W'(CRC_AT)) begin
        crc_received[15:8] <= rx;
      end
      if (byte_count == CNT_W'(CRC_AT + 1)) begin
        crc_received[7:0] <= rx;
      end
    end
  end

  // Body memory: one write port while collecting, one registered read port.
  logic [7:0]       body_mem [BODY_BYTES];
  logic [7:0]       body_rdata;
  logic [IDX_W-1:0] emit_index;

  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_body) begin
      body_mem[wr_addr] <= rx;
    end
    body_rdata <= body_mem[emit_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_index <= '0;
    end else if (cmd.latch_status) begin
      emit_index <= '0;
    end else if (cmd.step_index) begin
      emit_index <= emit_index + IDX_W'(1);
    end
  end

  // Frame check, first failure wins.
  logic [2:0] status_calc;
  logic [2:0] status_reg;
  logic [7:0] kind;
  logic [7:0] len;

  assign kind = hdr[ffpd_pkg::HDR_KIND];
  assign len = hdr[ffpd_pkg::HDR_LENGTH];

  always_comb begin
    if (byte_count != CNT_W'(FRAME_BYTES)) begin
      status_calc = ffpd_pkg::STATUS_LENGTH;
    end else if (hdr[ffpd_pkg::HDR_MAGIC0] != magic_first ||
                 hdr[ffpd_pkg::HDR_MAGIC1] != magic_second) begin
      status_calc = ffpd_pkg::STATUS_MAGIC;
    end else if (hdr[ffpd_pkg::HDR_VERSION] != format_version) begin
      status_calc = ffpd_pkg::STATUS_VERSION;
    end else if (kind < kind_min || kind > kind_max) begin
      status_calc = ffpd_pkg::STATUS_KIND;
    end else if (hdr[ffpd_pkg::HDR_TARGET] != node_address) begin
      status_calc = ffpd_pkg::STATUS_TARGET;
    end else if (len < {3'b000, body_length_min} || len > 8'(BODY_BYTES)) begin
      status_calc = ffpd_pkg::STATUS_BODY_LENGTH;
    end else if (crc_received != crc_register) begin
      status_calc = ffpd_pkg::STATUS_CRC;
    end else begin
      status_calc = ffpd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_status) begin
      status_reg <= status_calc;
    end
  end

  // Result register.
  ffpd_pkg::out_item_t item_next;
  logic                out_free;
  logic                last_index;

  assign out_free = !result_valid || result_ready;
  assign last_index = emit_index == IDX_W'(BODY_BYTES - 1);

  always_comb begin
    item_next = '0;
    if (cmd.load_error) begin
      item_next.status_code = status_reg;
      item_next.run_end = 1'b1;
    end else begin
      item_next.status_code = ffpd_pkg::STATUS_OK;
      item_next.msg_kind = kind;
      item_next.sender_node = hdr[ffpd_pkg::HDR_SENDER];
      item_next.target_node = hdr[ffpd_pkg::HDR_TARGET];
      item_next.seq_number = {hdr[ffpd_pkg::HDR_SEQ_HI], hdr[ffpd_pkg::HDR_SEQ_LO]};
      item_next.ack_number = {hdr[ffpd_pkg::HDR_ACK_HI], hdr[ffpd_pkg::HDR_ACK_LO]};
      item_next.body_length = len[4:0];
      item_next.flag_bits = hdr[ffpd_pkg::HDR_FLAGS];
      item_next.body_byte = body_rdata;
      item_next.body_index = 4'(emit_index);
      item_next.run_end = last_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_error || cmd.load_body) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_error || cmd.load_body) begin
      result_item <= item_next;
    end
  end

  assign sts.frame_ok = status_reg == ffpd_pkg::STATUS_OK;
  assign sts.last_index = last_index;
  assign sts.out_free = out_free;

`ifndef SYNTHESIS
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_status |=> byte_count == '0 && crc_register == ffpd_pkg::CRC_INIT)
    else $error("byte count or CRC not reloaded after frame end");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_error || cmd.load_body) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    cmd.load_error |=> result_item.run_end && result_item.body_index == 4'd0 &&
                       result_item.status_code != ffpd_pkg::STATUS_OK)
    else $error("error result malformed");

  a_body_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_body && last_index) |=> result_item.run_end &&
                                      result_item.body_index == 4'(BODY_BYTES - 1))
    else $error("last body result not marked");
`endif

endmodule
`default_nettype wire
